// ===== design/fcbs_pkg.sv =====
package fcbs_pkg;

  localparam int unsigned MS_W   = 10;
  localparam int unsigned BLINK_W = 3;
  localparam int unsigned FLAGS_W = 5;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = FLAGS_W;
  localparam int unsigned TDATA_W = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FAULT_FLAGS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE      = 1'd1;

  // phase codes as seen on the output
  localparam logic [1:0] PHASE_HEADER = 2'd0;
  localparam logic [1:0] PHASE_DETAIL = 2'd1;
  localparam logic [1:0] PHASE_GAP    = 2'd2;
  localparam logic [1:0] PHASE_IDLE   = 2'd3;

  localparam logic [MS_W-1:0] HEADER_ON_MS      = 10'd200;
  localparam logic [MS_W-1:0] HEADER_OFF_MS     = 10'd200;
  localparam logic [MS_W-1:0] BLUE_LIT_MS       = 10'd200;
  localparam logic [MS_W-1:0] DETAIL_OFF_NORMAL = 10'd500;
  localparam logic [MS_W-1:0] DETAIL_OFF_CLOCK  = 10'd300;
  localparam logic [MS_W-1:0] GAP_MS            = 10'd1000;
  localparam logic [BLINK_W-1:0] HEADER_BLINKS  = 3'd2;

  localparam logic [BLINK_W-1:0] BLINKS_IMU_BARO = 3'd5;
  localparam logic [BLINK_W-1:0] BLINKS_POWER    = 3'd2;
  localparam logic [BLINK_W-1:0] BLINKS_IMU      = 3'd3;
  localparam logic [BLINK_W-1:0] BLINKS_BARO     = 3'd4;
  localparam logic [BLINK_W-1:0] BLINKS_CLOCK    = 3'd6;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_write_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       blue_on;
    logic       red_on;
  } result_t;

endpackage

// ===== design/fcbs_core.sv =====
module fcbs_core
  import fcbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_write_t cfg,
  input  logic       tick,
  output result_t    result_next
);

  typedef enum logic [1:0] {
    ST_HEADER = 2'd0,
    ST_DETAIL = 2'd1,
    ST_GAP    = 2'd2,
    ST_IDLE   = 2'd3
  } state_t;

  state_t               state, state_next;
  logic [FLAGS_W-1:0]   fault_flags, fault_flags_next;
  logic [MS_W-1:0]      ms_count, ms_count_next;
  logic [BLINK_W-1:0]   blinks_left, blinks_left_next;
  logic                 lit_half, lit_half_next;
  logic [BLINK_W-1:0]   detail_count, detail_count_next;
  logic [MS_W-1:0]      blue_dark_ms, blue_dark_ms_next;

  logic [MS_W-1:0]      ms_inc;
  logic [MS_W-1:0]      half_len;
  logic [BLINK_W-1:0]   blinks_dec;
  logic                 imu, baro, pwr, clk_fault;
  logic [BLINK_W-1:0]   dec_count;
  logic [MS_W-1:0]      dec_off;

  // flag priority decode
  always_comb begin
    imu       = |fault_flags[1:0];
    baro      = fault_flags[2];
    pwr       = fault_flags[3];
    clk_fault = fault_flags[4];
    dec_off   = DETAIL_OFF_NORMAL;
    priority if (imu && baro) begin
      dec_count = BLINKS_IMU_BARO;
    end else if (pwr) begin
      dec_count = BLINKS_POWER;
    end else if (imu) begin
      dec_count = BLINKS_IMU;
    end else if (baro) begin
      dec_count = BLINKS_BARO;
    end else if (clk_fault) begin
      dec_count = BLINKS_CLOCK;
      dec_off   = DETAIL_OFF_CLOCK;
    end else begin
      dec_count = '0;
    end
  end

  always_comb begin
    unique case (state)
      ST_HEADER: half_len = lit_half ? HEADER_ON_MS : HEADER_OFF_MS;
      ST_DETAIL: half_len = lit_half ? BLUE_LIT_MS : blue_dark_ms;
      default:   half_len = GAP_MS;
    endcase
  end

  assign ms_inc     = ms_count + MS_W'(1);
  assign blinks_dec = blinks_left - BLINK_W'(1);

  always_comb begin
    state_next         = state;
    fault_flags_next   = fault_flags;
    ms_count_next      = ms_count;
    blinks_left_next   = blinks_left;
    lit_half_next      = lit_half;
    detail_count_next  = detail_count;
    blue_dark_ms_next  = blue_dark_ms;
    if (cfg.we) begin
      unique case (cfg.index)
        REG_FAULT_FLAGS: fault_flags_next = cfg.data[FLAGS_W-1:0];
        REG_ACTIVE: begin
          ms_count_next = '0;
          if (cfg.data[0]) begin
            state_next       = ST_HEADER;
            blinks_left_next = HEADER_BLINKS;
            lit_half_next    = 1'b1;
          end else begin
            state_next       = ST_IDLE;
            blinks_left_next = '0;
            lit_half_next    = 1'b0;
          end
        end
      endcase
    end else if (tick && state != ST_IDLE) begin
      if (ms_inc >= half_len) begin
        ms_count_next = '0;
        if (state == ST_GAP) begin
          state_next       = ST_HEADER;
          blinks_left_next = HEADER_BLINKS;
          lit_half_next    = 1'b1;
        end else if (lit_half) begin
          lit_half_next = 1'b0;
        end else if (blinks_dec != '0) begin
          blinks_left_next = blinks_dec;
          lit_half_next    = 1'b1;
        end else begin
          blinks_left_next = blinks_dec;
          lit_half_next    = 1'b0;
          state_next       = ST_GAP;
          // end of the red header: latch this pass's blue pattern
          if (state == ST_HEADER) begin
            detail_count_next = dec_count;
            blue_dark_ms_next = dec_off;
            if (dec_count != '0) begin
              state_next       = ST_DETAIL;
              blinks_left_next = dec_count;
              lit_half_next    = 1'b1;
            end
          end
        end
      end else begin
        ms_count_next = ms_inc;
      end
    end
  end

  always_comb begin
    result_next.phase   = 2'(state_next);
    result_next.red_on  = (state_next == ST_HEADER) && lit_half_next;
    result_next.blue_on = (state_next == ST_DETAIL) && lit_half_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      fault_flags   <= '0;
      ms_count      <= '0;
      blinks_left   <= '0;
      lit_half      <= 1'b0;
      detail_count  <= '0;
      blue_dark_ms  <= DETAIL_OFF_NORMAL;
    end else begin
      state         <= state_next;
      fault_flags   <= fault_flags_next;
      ms_count      <= ms_count_next;
      blinks_left   <= blinks_left_next;
      lit_half      <= lit_half_next;
      detail_count  <= detail_count_next;
      blue_dark_ms  <= blue_dark_ms_next;
    end
  end

endmodule

// ===== design/fault_code_blink_sequencer.sv =====
// the result of an accepted tick transaction is registered into the output buffer before it reaches m_tdata
// throughput: one tick per cycle while s_tready is high; the sequencer state updates in a single pass
// a two-entry output buffer keeps s_tready high while one result waits
// reset (rst, synchronous, active high): idle phase, leds dark, flags cleared,
// output buffer empty
module fault_code_blink_sequencer
  import fcbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [TDATA_W-1:0]    s_tdata,   // [0] ms_tick
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [TDATA_W-1:0]    m_tdata,   // [0] red_on, [1] blue_on, [3:2] phase
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_write_t cfg;
  result_t    result_next;
  result_t    out_data, skid_data;
  logic       skid_valid;
  logic       push, pop;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  assign s_tready = !skid_valid;
  assign push     = s_tvalid && s_tready;
  assign pop      = m_tvalid && m_tready;

  fcbs_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .tick        (push && s_tdata[0]),
    .result_next (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= push;
        if (push) skid_data <= result_next;
      end else begin
        m_tvalid <= push;
        if (push) out_data <= result_next;
      end
    end else if (push) begin
      if (!m_tvalid) begin
        out_data <= result_next;
        m_tvalid <= 1'b1;
      end else begin
        skid_data  <= result_next;
        skid_valid <= 1'b1;
      end
    end
  end

  assign m_tdata = {{(TDATA_W-$bits(result_t)){1'b0}}, out_data};

endmodule

// ===== design/fcbs_checker.sv =====
module fcbs_checker
  import fcbs_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [TDATA_W-1:0]    s_tdata,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [TDATA_W-1:0]    m_tdata,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  a_leds_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("red and blue lit together");

  a_red_in_header: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> (m_tdata[3:2] == PHASE_HEADER))
    else $error("red lit outside header");

  a_blue_in_detail: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1]) |-> (m_tdata[3:2] == PHASE_DETAIL))
    else $error("blue lit outside detail blinks");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind fault_code_blink_sequencer fcbs_checker u_fcbs_checker (.*);
